>>> rtl/core/pms_pkg.sv
package pms_pkg;

    // splitmix64 finaliser constants
    localparam logic [63:0] MIX_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_C1     = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_C2     = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] SEED_MULT  = 64'h0000_0100_0000_01B3;
    localparam int          MIX_SH1    = 30;
    localparam int          MIX_SH2    = 27;
    localparam int          MIX_SH3    = 31;

    // pipeline shape
    localparam int MIX_DEPTH  = 5;
    localparam int PMS_STAGES = 2 * MIX_DEPTH + 2;

    // configuration port
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [1:0] {
        KIND_PERIODIC = 2'd0,
        KIND_RANDOM   = 2'd1,
        KIND_FLIP     = 2'd2
    } map_kind_t;

    typedef enum logic [2:0] {
        REG_MAP_KIND    = 3'd0,
        REG_PAIR_OFFSET = 3'd1,
        REG_PERIOD_BITS = 3'd2,
        REG_PATTERN     = 3'd3,
        REG_THRESHOLD   = 3'd4,
        REG_FLIP_COUNT  = 3'd5,
        REG_FLIP_FIRST  = 3'd6,
        REG_FLIP_SECOND = 3'd7
    } pms_reg_t;

    typedef struct packed {
        map_kind_t   map_kind;
        logic        pair_offset;
        logic [2:0]  period_bits;
        logic [63:0] pattern_or_seed;
        logic [63:0] flip_threshold;
        logic [1:0]  flip_count;
        logic [62:0] first_flip_pair;
        logic [62:0] second_flip_pair;
    } pms_cfg_t;

    // fields that ride beside the hash pipeline
    typedef struct packed {
        logic [63:0] idx;
        logic [64:0] up_sum;
        logic [63:0] down_diff;
        logic        parity;
        logic        cfast;
    } pms_side_t;

    // mask for i mod 2^K, K clamped to 6
    function automatic logic [5:0] period_mask(input logic [2:0] k);
        logic [2:0] kk;
        kk = (k > 3'd6) ? 3'd6 : k;
        return 6'((7'd1 << kk) - 7'd1);
    endfunction

endpackage

>>> rtl/core/pairing_map_step_core.sv
// One step of a generalised pairing map per item. For input n the pair index
// is i = ceil(n/2) (pair offset 0) or floor(n/2) (offset 1); a choice bit c
// comes from a periodic pattern, a seeded splitmix hash compared with a
// threshold, or a two-slot flip list. The result is n+i when n[0]^c is 1
// (saturating to all ones, with overflow flagged) and n-i otherwise.
// Throughput is one item per cycle while the m_ side keeps accepting; the
// depth is set by the hash path: two chained splitmix finalisers, four
// 64-bit multiplies, each split into a 32x32 partial-product stage and a
// sum stage. Every stage holds its own valid bit and empty stages close up
// under output back-pressure, so input keeps flowing until all twelve
// stages are full. Registers sit on an APB port at byte address 8*index,
// 64-bit data; write them only while no item is in flight.
module pairing_map_step_core
    import pms_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // [63:0] value_in
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [127:0]          m_tdata,   // [63:0] value_out, [127:64] pair_index
    output logic [1:0]            m_tuser,   // [0] went_up, [1] overflowed
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LAST = PMS_STAGES - 1;   // output stage
    localparam int SIDE = PMS_STAGES - 2;   // side-data stages 1..SIDE

    pms_cfg_t cfg;

    // per-stage valid and advance
    logic [PMS_STAGES-1:0] vld_reg;
    logic [PMS_STAGES-1:0] vld_next;
    logic [PMS_STAGES-1:0] adv;

    // stage 0: value and pair index
    logic [63:0] n_reg;
    logic [63:0] idx_reg;
    logic [63:0] idx_next;

    // side data beside the hash
    pms_side_t side_reg [1:SIDE];
    pms_side_t side_next;
    logic [5:0] period_sel;
    logic [1:0] flip_cnt;

    // hash path
    logic [63:0] seed_prod;
    logic [63:0] h_idx;
    logic [63:0] h_fin;

    // output stage
    logic [63:0] out_value_reg;
    logic [63:0] out_index_reg;
    logic        out_up_reg;
    logic        out_ovf_reg;
    logic        choice;
    logic        up;
    logic        ovf;

    pms_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- flow control ----------------
    // A stage takes new contents when it is empty or its successor advances.
    assign adv[LAST] = !vld_reg[LAST] || m_tready;
    genvar g;
    generate
        for (g = 0; g < LAST; g++) begin : g_adv
            assign adv[g] = !vld_reg[g] || adv[g+1];
        end
    endgenerate

    assign s_tready = adv[0];

    always_comb begin
        vld_next = vld_reg;
        if (adv[0]) begin
            vld_next[0] = s_tvalid;
        end
        for (int k = 1; k < PMS_STAGES; k++) begin
            if (adv[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // ---------------- stage 0: pair index ----------------
    assign idx_next = {1'b0, s_tdata[63:1]} + {63'd0, s_tdata[0] & !cfg.pair_offset};

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            n_reg   <= s_tdata;
            idx_reg <= idx_next;
        end
    end

    // ---------------- stage 1: add/sub and the cheap choice sources ----------------
    assign period_sel = idx_reg[5:0] & period_mask(cfg.period_bits);
    assign flip_cnt   = (cfg.flip_count == 2'd3) ? 2'd2 : cfg.flip_count;

    always_comb begin
        side_next.idx       = idx_reg;
        side_next.up_sum    = {1'b0, n_reg} + {1'b0, idx_reg};
        side_next.down_diff = n_reg - idx_reg;
        side_next.parity    = n_reg[0];
        case (cfg.map_kind)
            KIND_PERIODIC: side_next.cfast = cfg.pattern_or_seed[period_sel];
            KIND_FLIP: begin
                // i = 2^63 has bit 63 set and never matches a 63-bit slot
                side_next.cfast =
                    ((flip_cnt != 2'd0) && (idx_reg == {1'b0, cfg.first_flip_pair})) ||
                    ((flip_cnt == 2'd2) && (idx_reg == {1'b0, cfg.second_flip_pair}));
            end
            default: side_next.cfast = 1'b0;   // random mode decided at the end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            side_reg[1] <= side_next;
        end
        for (int k = 2; k <= SIDE; k++) begin
            if (adv[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------- hash path ----------------
    // seed product is free running off the register, through the partial-product and sum registers
    pms_mul u_seed_mul (
        .aclk (aclk),
        .en   (2'b11),
        .a    (cfg.pattern_or_seed),
        .coef (SEED_MULT),
        .prod (seed_prod)
    );

    // stages 1..5: mix(i)
    pms_mix u_mix_idx (
        .aclk  (aclk),
        .en    (adv[MIX_DEPTH:1]),
        .x_in  (idx_reg),
        .h_out (h_idx)
    );

    // stages 6..10: mix(seed*C ^ mix(i))
    pms_mix u_mix_fin (
        .aclk  (aclk),
        .en    (adv[2*MIX_DEPTH:MIX_DEPTH+1]),
        .x_in  (seed_prod ^ h_idx),
        .h_out (h_fin)
    );

    // ---------------- output stage ----------------
    assign choice = (cfg.map_kind == KIND_RANDOM) ? (h_fin < cfg.flip_threshold)
                                                  : side_reg[SIDE].cfast;
    assign up     = side_reg[SIDE].parity ^ choice;
    assign ovf    = up && side_reg[SIDE].up_sum[64];

    always_ff @(posedge aclk) begin
        if (adv[LAST]) begin
            out_index_reg <= side_reg[SIDE].idx;
            out_up_reg    <= up;
            out_ovf_reg   <= ovf;
            if (!up) begin
                out_value_reg <= side_reg[SIDE].down_diff;
            end else if (ovf) begin
                out_value_reg <= '1;
            end else begin
                out_value_reg <= side_reg[SIDE].up_sum[63:0];
            end
        end
    end

    assign m_tvalid = vld_reg[LAST];
    assign m_tdata  = {out_index_reg, out_value_reg};
    assign m_tuser  = {out_ovf_reg, out_up_reg};

    // ---------------- checks ----------------
    // overflow only ever on the up branch
    a_ovf_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("overflow flagged on a down step");

    // saturated result is all ones
    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata[63:0] == '1))
        else $error("overflow without saturation");

    // pair index never exceeds 2^63
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[127] && (m_tdata[126:64] != '0)))
        else $error("pair index out of range");

    // input is only held off when every stage is occupied and output is stalled
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> ((vld_reg == '1) && !m_tready))
        else $error("input stalled with a free stage");

endmodule

>>> rtl/core/pms_cfg.sv
module pms_cfg
    import pms_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output pms_cfg_t              cfg
);

    pms_cfg_t cfg_reg;
    pms_reg_t sel_reg_idx;
    logic     wr_en;

    assign pready      = 1'b1;
    assign sel_reg_idx = pms_reg_t'(paddr[CFG_ADDR_W-1:3]);
    assign wr_en       = psel && penable && pwrite;
    assign cfg         = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (sel_reg_idx)
                REG_MAP_KIND:    cfg_reg.map_kind <= map_kind_t'(pwdata[1:0]);
                REG_PAIR_OFFSET: cfg_reg.pair_offset <= pwdata[0];
                REG_PERIOD_BITS: cfg_reg.period_bits <= pwdata[2:0];
                REG_PATTERN:     cfg_reg.pattern_or_seed <= pwdata;
                REG_THRESHOLD:   cfg_reg.flip_threshold <= pwdata;
                REG_FLIP_COUNT:  cfg_reg.flip_count <= pwdata[1:0];
                REG_FLIP_FIRST:  cfg_reg.first_flip_pair <= pwdata[62:0];
                REG_FLIP_SECOND: cfg_reg.second_flip_pair <= pwdata[62:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel_reg_idx)
            REG_MAP_KIND:    prdata = {62'd0, cfg_reg.map_kind};
            REG_PAIR_OFFSET: prdata = {63'd0, cfg_reg.pair_offset};
            REG_PERIOD_BITS: prdata = {61'd0, cfg_reg.period_bits};
            REG_PATTERN:     prdata = cfg_reg.pattern_or_seed;
            REG_THRESHOLD:   prdata = cfg_reg.flip_threshold;
            REG_FLIP_COUNT:  prdata = {62'd0, cfg_reg.flip_count};
            REG_FLIP_FIRST:  prdata = {1'b0, cfg_reg.first_flip_pair};
            REG_FLIP_SECOND: prdata = {1'b0, cfg_reg.second_flip_pair};
            default:         prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/pms_mul.sv
// 64x64 multiply mod 2^64, split into 32x32 partial products then a sum stage
module pms_mul
    import pms_pkg::*;
(
    input  logic        aclk,
    input  logic [1:0]  en,
    input  logic [63:0] a,
    input  logic [63:0] coef,
    output logic [63:0] prod
);

    logic [63:0] p_ll_reg;
    logic [31:0] p_hl_reg;
    logic [31:0] p_lh_reg;
    logic [63:0] p_ll_next;
    logic [31:0] p_hl_next;
    logic [31:0] p_lh_next;
    logic [31:0] cross_sum;
    logic [63:0] prod_reg;

    assign p_ll_next = 64'(a[31:0]) * 64'(coef[31:0]);
    assign p_hl_next = a[63:32] * coef[31:0];   // only low half survives
    assign p_lh_next = a[31:0] * coef[63:32];
    assign cross_sum = p_hl_reg + p_lh_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p_ll_reg <= p_ll_next;
            p_hl_reg <= p_hl_next;
            p_lh_reg <= p_lh_next;
        end
        if (en[1]) begin
            prod_reg <= p_ll_reg + {cross_sum, 32'd0};
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/core/pms_mix.sv
// splitmix64 finaliser, five register stages; final xor-shift is combinational
module pms_mix
    import pms_pkg::*;
(
    input  logic                 aclk,
    input  logic [MIX_DEPTH-1:0] en,
    input  logic [63:0]          x_in,
    output logic [63:0]          h_out
);

    logic [63:0] x0;
    logic [63:0] pre_reg;
    logic [63:0] y;
    logic [63:0] mid;
    logic [63:0] z;

    assign x0 = x_in + MIX_GOLDEN;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pre_reg <= x0 ^ (x0 >> MIX_SH1);
        end
    end

    pms_mul u_mul_a (
        .aclk (aclk),
        .en   (en[2:1]),
        .a    (pre_reg),
        .coef (MIX_C1),
        .prod (y)
    );

    assign mid = y ^ (y >> MIX_SH2);

    pms_mul u_mul_b (
        .aclk (aclk),
        .en   (en[4:3]),
        .a    (mid),
        .coef (MIX_C2),
        .prod (z)
    );

    assign h_out = z ^ (z >> MIX_SH3);

endmodule

>>> tb/tb_pairing_map_step_core.sv
`timescale 1ns / 1ps

module tb_pairing_map_step_core;
    import pms_pkg::*;

    // map kind 3 has no choice source: choice bit stays 0
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         LONG_HOLD   = 200;   // receiver hold-off, in cycles
    localparam int         MAX_REPORTS = 40;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input item channel
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata  = '0;    // [63:0] value_in
    // result item channel
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;          // [63:0] value_out, [127:64] pair_index
    logic [1:0]   m_tuser;          // [0] went_up, [1] overflowed
    // register port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    pairing_map_step_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // one step of the map, as the block should produce it
    typedef struct {
        logic [63:0] value_out;
        logic        went_up;
        logic [63:0] pair_index;
        logic        overflowed;
    } map_step_t;

    // an input value waiting to be offered; hold_for_drain makes the sender
    // wait until every outstanding step has come back first
    typedef struct {
        logic [63:0] value;
        logic        hold_for_drain;
    } orbit_item_t;

    orbit_item_t orbit_values_q[$];
    map_step_t   next_step_q[$];

    // local copy of the register file
    logic [1:0]  cfg_kind        = KIND_PERIODIC;
    logic        cfg_offset      = 1'b0;
    logic [2:0]  cfg_period      = '0;
    logic [63:0] cfg_pattern     = '0;
    logic [63:0] cfg_threshold   = '0;
    logic [1:0]  cfg_flip_count  = '0;
    logic [62:0] cfg_flip_first  = '0;
    logic [62:0] cfg_flip_second = '0;

    int mismatch_count = 0;
    bit no_gaps        = 1'b0;   // both sides run flat out when set
    int hold_requests  = 0;      // bumped to ask the receiver for a long hold-off

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] splitmix(input logic [63:0] x);
        logic [63:0] z;
        z = x + MIX_GOLDEN;
        z = (z ^ (z >> MIX_SH1)) * MIX_C1;
        z = (z ^ (z >> MIX_SH2)) * MIX_C2;
        return z ^ (z >> MIX_SH3);
    endfunction

    function automatic logic choice_for_pair(input logic [63:0] idx);
        logic [2:0]  k;
        logic [6:0]  span;
        logic [5:0]  sel;
        logic [63:0] seeded;
        case (cfg_kind)
            KIND_PERIODIC: begin
                // period bits above 6 clamp to a 64-bit period
                k    = (cfg_period > 3'd6) ? 3'd6 : cfg_period;
                span = (7'd1 << k) - 7'd1;
                sel  = idx[5:0] & span[5:0];
                return cfg_pattern[sel];
            end
            KIND_RANDOM: begin
                seeded = cfg_pattern * SEED_MULT;
                return splitmix(seeded ^ splitmix(idx)) < cfg_threshold;
            end
            KIND_FLIP: begin
                // a flip count of 3 acts as 2; i = 2^63 never hits a 63-bit slot
                if (cfg_flip_count >= 2'd1 && idx == {1'b0, cfg_flip_first})
                    return 1'b1;
                if (cfg_flip_count >= 2'd2 && idx == {1'b0, cfg_flip_second})
                    return 1'b1;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic map_step_t predict_step(input logic [63:0] n);
        map_step_t  r;
        logic [64:0] wide_sum;
        r.pair_index = (n >> 1) + ((cfg_offset == 1'b0) ? {63'd0, n[0]} : 64'd0);
        r.went_up    = n[0] ^ choice_for_pair(r.pair_index);
        r.overflowed = 1'b0;
        if (r.went_up) begin
            wide_sum = {1'b0, n} + {1'b0, r.pair_index};
            if (wide_sum[64]) begin
                r.value_out  = '1;
                r.overflowed = 1'b1;
            end else begin
                r.value_out = wide_sum[63:0];
            end
        end else begin
            r.value_out = n - r.pair_index;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // sender: offers queued values, with a random idle gap between items
    // ------------------------------------------------------------------
    int          send_gap = 0;
    orbit_item_t offer;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                next_step_q.push_back(predict_step(s_tdata));

            if (s_tvalid && !s_tready) begin
                // stalled: hold the item as it is
            end else if (send_gap != 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (orbit_values_q.size() != 0 &&
                         !(orbit_values_q[0].hold_for_drain && next_step_q.size() != 0)) begin
                offer = orbit_values_q.pop_front();
                s_tdata  <= offer.value;
                s_tvalid <= 1'b1;
                send_gap = no_gaps ? 0 : $urandom_range(0, 4);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: checks each result item against the oldest prediction,
    // random stall after each item, plus the long hold-off on request
    // ------------------------------------------------------------------
    int        ready_gap  = 0;
    int        hold_left  = 0;
    int        holds_done = 0;
    map_step_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_gap = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (next_step_q.size() == 0) begin
                    report_mismatch("result item with nothing expected", m_tdata[63:0], '0);
                end else begin
                    want = next_step_q.pop_front();
                    if (m_tdata[63:0] !== want.value_out)
                        report_mismatch("value_out", m_tdata[63:0], want.value_out);
                    if (m_tdata[127:64] !== want.pair_index)
                        report_mismatch("pair_index", m_tdata[127:64], want.pair_index);
                    if (m_tuser[0] !== want.went_up)
                        report_mismatch("went_up", 64'(m_tuser[0]), 64'(want.went_up));
                    if (m_tuser[1] !== want.overflowed)
                        report_mismatch("overflowed", 64'(m_tuser[1]), 64'(want.overflowed));
                end
            end

            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                hold_left  = LONG_HOLD;
            end

            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                ready_gap = no_gaps ? 0 : $urandom_range(0, 4);
                m_tready <= (ready_gap == 0);
            end else if (ready_gap != 0) begin
                ready_gap--;
                m_tready <= (ready_gap == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input pms_reg_t idx, input logic [63:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);   // access cycle completes here, pready is tied high
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MAP_KIND:    cfg_kind        = val[1:0];
            REG_PAIR_OFFSET: cfg_offset      = val[0];
            REG_PERIOD_BITS: cfg_period      = val[2:0];
            REG_PATTERN:     cfg_pattern     = val;
            REG_THRESHOLD:   cfg_threshold   = val;
            REG_FLIP_COUNT:  cfg_flip_count  = val[1:0];
            REG_FLIP_FIRST:  cfg_flip_first  = val[62:0];
            REG_FLIP_SECOND: cfg_flip_second = val[62:0];
            default: ;
        endcase
    endtask

    task automatic set_map(input logic [1:0] kind, input logic offset, input logic [2:0] k,
                           input logic [63:0] pattern, input logic [63:0] threshold,
                           input logic [1:0] flips, input logic [63:0] flip_a,
                           input logic [63:0] flip_b);
        write_reg(REG_MAP_KIND,    64'(kind));
        write_reg(REG_PAIR_OFFSET, 64'(offset));
        write_reg(REG_PERIOD_BITS, 64'(k));
        write_reg(REG_PATTERN,     pattern);
        write_reg(REG_THRESHOLD,   threshold);
        write_reg(REG_FLIP_COUNT,  64'(flips));
        write_reg(REG_FLIP_FIRST,  flip_a);
        write_reg(REG_FLIP_SECOND, flip_b);
    endtask

    // wait until nothing is queued, offered or in flight, then let the
    // pipeline settle before any register write
    task automatic wait_idle();
        while (orbit_values_q.size() != 0 || s_tvalid || next_step_q.size() != 0)
            @(posedge aclk);
        repeat (PMS_STAGES + 4) @(posedge aclk);
    endtask

    task automatic push_value(input logic [63:0] v, input logic drain);
        orbit_item_t it;
        it.value          = v;
        it.hold_for_drain = drain;
        orbit_values_q.push_back(it);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // biased towards the corners: small values, the overflow region, the
    // half-range boundary, and in flip mode values whose pair hits a slot
    function automatic logic [63:0] draw_value();
        logic [63:0] slot;
        case ($urandom_range(0, 9))
            0: return 64'($urandom_range(0, 15));
            1: return ~64'($urandom_range(0, 15));
            2: return {1'b1, 63'd0} + 64'($urandom_range(0, 7)) - 64'd4;
            3, 4: begin
                if (cfg_kind != KIND_FLIP)
                    return rand64();
                slot = {1'b0, $urandom_range(0, 1) ? cfg_flip_first : cfg_flip_second};
                return (slot << 1) + 64'($urandom_range(0, 2)) - 64'd1;
            end
            default: return rand64();
        endcase
    endfunction

    task automatic queue_random(input int count);
        repeat (count)
            push_value(draw_value(), $urandom_range(0, 59) == 0);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset settings: periodic, zero pattern, so up only for odd n
        push_value(64'd0, 1'b0);
        push_value(64'd1, 1'b0);
        push_value(64'd2, 1'b0);
        push_value(64'd3, 1'b0);
        push_value('1, 1'b0);                          // saturates, i = 2^63
        push_value(~64'd1, 1'b0);
        push_value({1'b1, 63'd0}, 1'b0);
        push_value({1'b0, {63{1'b1}}}, 1'b0);
        push_value({32{2'b10}}, 1'b0);
        push_value({32{2'b01}}, 1'b0);
        push_value({{31{2'b10}}, 2'b11}, 1'b1);       // odd, overflows, after a drain
        wait_idle();

        // periodic, floor pairing, full 64-bit period
        set_map(KIND_PERIODIC, 1'b1, 3'd6, rand64(), rand64(), 2'd0, '0, '0);
        queue_random(130);
        wait_idle();

        // period bits 7 clamp to 6; all-ones pattern flips every step
        no_gaps = 1'b1;
        set_map(KIND_PERIODIC, 1'b0, 3'd7, '1, '0, 2'd3, '1, '1);
        push_value('1, 1'b0);
        push_value(~64'd1, 1'b0);
        queue_random(100);
        wait_idle();
        no_gaps = 1'b0;

        // short period
        set_map(KIND_PERIODIC, 1'b1, 3'd3, rand64(), '0, 2'd1, rand64(), rand64());
        queue_random(100);
        wait_idle();

        // hashed choice at half threshold; receiver holds off while the
        // sender keeps going, so the pipeline fills and input stalls
        no_gaps = 1'b1;
        set_map(KIND_RANDOM, 1'b0, 3'd2, rand64(), {1'b1, 63'd0}, 2'd2, rand64(), rand64());
        queue_random(150);
        hold_requests <= hold_requests + 1;
        wait_idle();
        no_gaps = 1'b0;

        // hashed, threshold 0: choice never set
        set_map(KIND_RANDOM, 1'b1, 3'd0, '0, '0, 2'd0, '0, '0);
        queue_random(60);
        wait_idle();

        // hashed, threshold all ones: choice nearly always set
        set_map(KIND_RANDOM, 1'b0, 3'd5, '1, '1, 2'd3, '0, '0);
        queue_random(60);
        wait_idle();

        // flip list, both slots, ceiling pairing
        set_map(KIND_FLIP, 1'b0, 3'd1, rand64(), rand64(), 2'd2,
                64'($urandom_range(0, 1000)), rand64());
        queue_random(150);
        wait_idle();

        // flip count 3 acts as 2; slots at the extremes, pair 2^63-1 and 0 hit
        no_gaps = 1'b1;
        set_map(KIND_FLIP, 1'b1, 3'd4, rand64(), rand64(), 2'd3, '0, {1'b0, {63{1'b1}}});
        push_value('1, 1'b0);
        push_value(~64'd1, 1'b0);
        push_value(64'd0, 1'b0);
        push_value(64'd1, 1'b0);
        queue_random(100);
        wait_idle();
        no_gaps = 1'b0;

        // one slot active; ceiling pairing with slot 2^63-1
        set_map(KIND_FLIP, 1'b0, 3'd6, rand64(), rand64(), 2'd1, '1, rand64());
        push_value('1, 1'b0);
        push_value(~64'd2, 1'b0);
        queue_random(100);
        wait_idle();

        // no slot active
        set_map(KIND_FLIP, 1'b1, 3'd2, rand64(), rand64(), 2'd0, rand64(), rand64());
        queue_random(60);
        wait_idle();

        // unused kind: choice bit 0
        set_map(KIND_UNUSED, 1'b0, 3'd6, '1, '1, 2'd2, '0, '0);
        push_value('1, 1'b0);
        queue_random(60);
        wait_idle();

        // period of one: every pair uses bit 0 of the pattern
        set_map(KIND_PERIODIC, 1'b0, 3'd0, 64'd1, rand64(), 2'd0, '0, '0);
        queue_random(100);
        wait_idle();

        // random period and pattern to finish
        set_map(KIND_PERIODIC, 1'b1, 3'($urandom_range(0, 7)), rand64(), '0, 2'd0, '0, '0);
        queue_random(100);
        wait_idle();

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("pairing_map_step_core verification clean");
        else
            $display("pairing_map_step_core verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("pairing_map_step_core verification failed");
        $finish;
    end

endmodule
